>>> rtl/core/bfd_pkg.sv
// Shared constants, codes and types of the box filter downscaler.
`default_nettype none

package bfd_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_FACTOR = 16;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned LANES       = 4;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned FACTOR_W    = 5;
  localparam int unsigned DIV_W       = 2 * FACTOR_W;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned LVL_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_FACTOR_X     = 2'd2,
    CFG_FACTOR_Y     = 2'd3
  } bfd_cfg_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } bfd_back_e;

  typedef struct packed {
    logic row_end;
    logic frame_end;
  } bfd_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/box_filter_image_downscaler_core.sv
// Top level of the box filter downscaler: front end, box queue and divider.
//
// Source RGBA pixels enter in raster order through a queue-like port: a pixel
// transfers at a clock edge with push high and full low. Averaged output
// pixels leave the same way: while empty is low the oldest result is on the
// output ports, and it transfers at an edge with pop high.
// The front end takes one pixel per cycle while full is low. It updates
// one accumulator entry per box column in a line RAM (read, add, write
// back, with a bypass for back-to-back pixels of the same box). A pixel
// that closes a box is pushed into a four-entry queue in the cycle after
// its transfer. The divider handles one box at a time and takes the next
// only after the last result has moved into the result register; it works
// one quotient bit per cycle in each of the four channel lanes. That
// divider sets the sustained output rate; pixels that close no box flow at
// one per cycle while full is low. A closing pixel passes stage two, the
// box queue, the divider and the result register before its result appears.
// If the receiver stalls, the finished result is held, the divider waits,
// the queue fills and full rises to stop further pixels.
// Reset clears the raster counters, the queue and the result register, and
// sets all four configuration registers to one. The accumulator line needs
// no clearing: the first row of each band overwrites its entries.
// Configuration is written through cfg_we_i, cfg_index_i and cfg_wdata_i;
// the user must write it only while the block is idle, which the block does not enforce.
`default_nettype none

module box_filter_image_downscaler_core #(
  parameter int unsigned MAX_WIDTH  = bfd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [bfd_pkg::DIM_W-1:0]     cfg_wdata_i,
  input  wire logic                          push,
  output      logic                          full,
  input  wire logic [bfd_pkg::PIX_W-1:0]     red_in_i,
  input  wire logic [bfd_pkg::PIX_W-1:0]     green_in_i,
  input  wire logic [bfd_pkg::PIX_W-1:0]     blue_in_i,
  input  wire logic [bfd_pkg::PIX_W-1:0]     alpha_in_i,
  output      logic                          empty,
  input  wire logic                          pop,
  output      logic [bfd_pkg::PIX_W-1:0]     red_out_o,
  output      logic [bfd_pkg::PIX_W-1:0]     green_out_o,
  output      logic [bfd_pkg::PIX_W-1:0]     blue_out_o,
  output      logic [bfd_pkg::PIX_W-1:0]     alpha_out_o,
  output      logic                          row_end_o,
  output      logic                          frame_end_o
);
  import bfd_pkg::*;

  localparam int unsigned SUM_W  = PIX_W + 2 * $clog2(MAX_FACTOR);
  localparam int unsigned SUMS_W = LANES * SUM_W;
  localparam int unsigned FLG_W  = $bits(bfd_flags_t);
  localparam int unsigned JOB_W  = SUMS_W + DIV_W + FLG_W;

  logic [SUMS_W-1:0] f_sums, b_sums;
  logic [DIV_W-1:0]  f_div, b_div;
  bfd_flags_t        f_flags, b_flags;
  logic              q_push, q_pop, q_empty;
  logic [LVL_W-1:0]  q_level;
  logic [JOB_W-1:0]  q_in, q_out;

  bfd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push),
    .pix_i       ({alpha_in_i, blue_in_i, green_in_i, red_in_i}),
    .full_o      (full),
    .q_level_i   (q_level),
    .job_valid_o (q_push),
    .job_sums_o  (f_sums),
    .job_div_o   (f_div),
    .job_flags_o (f_flags)
  );

  assign q_in = {f_flags, f_div, f_sums};

  bfd_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty),
    .level_o (q_level)
  );

  assign b_sums  = q_out[SUMS_W-1:0];
  assign b_div   = q_out[SUMS_W +: DIV_W];
  assign b_flags = bfd_flags_t'(q_out[JOB_W-1 -: FLG_W]);

  bfd_back #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_ready_i (!q_empty),
    .job_sums_i  (b_sums),
    .job_div_i   (b_div),
    .job_flags_i (b_flags),
    .job_pop_o   (q_pop),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .alpha_out_o (alpha_out_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o),
    .empty       (empty),
    .pop         (pop)
  );

  // The front end's reservation must leave room for every closed box.
  a_queue_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (32'(q_level) < QUEUE_DEPTH || q_pop))
    else $error("box queue written while full");

  a_queue_pop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("box queue read while empty");

  // The last pixel of the image is always the last of its output row.
  a_frame_row : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_end_o) |-> row_end_o)
    else $error("frame end without row end");

endmodule

`default_nettype wire

>>> rtl/core/bfd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bfd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/bfd_front.sv
// Front end: configuration, raster counters and the accumulator line update.
`default_nettype none

module bfd_front #(
  parameter int unsigned MAX_WIDTH  = bfd_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_we_i,
  input  wire logic [bfd_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  wire logic [bfd_pkg::DIM_W-1:0]              cfg_wdata_i,
  input  wire logic                                   push_i,
  input  wire logic [bfd_pkg::LANES*bfd_pkg::PIX_W-1:0] pix_i,
  output      logic                                   full_o,
  input  wire logic [bfd_pkg::LVL_W-1:0]              q_level_i,
  output      logic                                   job_valid_o,
  output      logic [bfd_pkg::LANES*(bfd_pkg::PIX_W+2*$clog2(MAX_FACTOR))-1:0] job_sums_o,
  output      logic [bfd_pkg::DIV_W-1:0]              job_div_o,
  output      bfd_pkg::bfd_flags_t                    job_flags_o
);
  import bfd_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned PH_W  = $clog2(MAX_FACTOR);
  localparam int unsigned SUM_W = PIX_W + 2 * PH_W;
  localparam int unsigned CCW   = (COL_W > DIM_W) ? COL_W : DIM_W;
  localparam int unsigned PCW   = (PH_W > FACTOR_W) ? PH_W : FACTOR_W;
  localparam int unsigned ENT_W = LANES * SUM_W;

  // Configuration registers.
  logic [DIM_W-1:0]    width_q, height_q;
  logic [FACTOR_W-1:0] fx_q, fy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      fx_q     <= FACTOR_W'(1);
      fy_q     <= FACTOR_W'(1);
    end else if (cfg_we_i) begin
      unique case (bfd_cfg_e'(cfg_index_i))
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        CFG_FACTOR_X:     fx_q     <= cfg_wdata_i[FACTOR_W-1:0];
        CFG_FACTOR_Y:     fy_q     <= cfg_wdata_i[FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]    w_c, h_c, w_m1, h_m1;
  logic [FACTOR_W-1:0] fx_c, fy_c, fx_m1, fy_m1;

  // Zero reads as one; width and factors saturate at their maxima.
  always_comb begin
    if (width_q == '0) begin
      w_c = DIM_W'(1);
    end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
      w_c = DIM_W'(MAX_WIDTH);
    end else begin
      w_c = width_q;
    end
    h_c = (height_q == '0) ? DIM_W'(1) : height_q;
    if (fx_q == '0) begin
      fx_c = FACTOR_W'(1);
    end else if (32'(fx_q) > 32'(MAX_FACTOR)) begin
      fx_c = FACTOR_W'(MAX_FACTOR);
    end else begin
      fx_c = fx_q;
    end
    if (fy_q == '0) begin
      fy_c = FACTOR_W'(1);
    end else if (32'(fy_q) > 32'(MAX_FACTOR)) begin
      fy_c = FACTOR_W'(MAX_FACTOR);
    end else begin
      fy_c = fy_q;
    end
    w_m1  = w_c - DIM_W'(1);
    h_m1  = h_c - DIM_W'(1);
    fx_m1 = fx_c - FACTOR_W'(1);
    fy_m1 = fy_c - FACTOR_W'(1);
  end

  // Raster position.
  logic [COL_W-1:0] col_q, col_d, ocol_q, ocol_d;
  logic [DIM_W-1:0] row_q, row_d;
  logic [PH_W-1:0]  bph_q, bph_d, rph_q, rph_d;
  logic             last_col, last_row, box_x_end, band_end, accept;

  // Stage two: the pixel whose accumulator entry is being read.
  logic             s2_valid_q, s2_first_q, s2_close_q;
  bfd_flags_t       s2_flags_q;
  logic [COL_W-1:0] s2_slot_q;
  logic [LANES*PIX_W-1:0] s2_pix_q;
  logic [DIV_W-1:0] s2_div_q;
  logic             byp_q;
  logic [ENT_W-1:0] byp_sum_q;
  logic [ENT_W-1:0] ram_rdata, new_sum;
  logic             pending;

  assign last_col  = CCW'(col_q) >= CCW'(w_m1);
  assign last_row  = row_q >= h_m1;
  assign box_x_end = last_col || (PCW'(bph_q) >= PCW'(fx_m1));
  assign band_end  = last_row || (PCW'(rph_q) >= PCW'(fy_m1));

  // Room is kept in the queue for a closing pixel still in stage two.
  assign pending = s2_valid_q && s2_close_q;
  assign full_o  = ({1'b0, q_level_i} + (LVL_W+1)'(pending)) >= (LVL_W+1)'(QUEUE_DEPTH);
  assign accept  = push_i && !full_o;

  always_comb begin
    col_d  = col_q;
    ocol_d = ocol_q;
    row_d  = row_q;
    bph_d  = bph_q;
    rph_d  = rph_q;
    if (last_col) begin
      col_d  = '0;
      bph_d  = '0;
      ocol_d = '0;
      if (last_row) begin
        row_d = '0;
        rph_d = '0;
      end else begin
        row_d = row_q + DIM_W'(1);
        rph_d = band_end ? '0 : rph_q + PH_W'(1);
      end
    end else begin
      col_d = col_q + COL_W'(1);
      if (box_x_end) begin
        bph_d  = '0;
        ocol_d = ocol_q + COL_W'(1);
      end else begin
        bph_d = bph_q + PH_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      ocol_q     <= '0;
      row_q      <= '0;
      bph_q      <= '0;
      rph_q      <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= accept;
      if (accept) begin
        col_q  <= col_d;
        ocol_q <= ocol_d;
        row_q  <= row_d;
        bph_q  <= bph_d;
        rph_q  <= rph_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_first_q           <= (rph_q == '0);
      s2_close_q           <= box_x_end && band_end;
      s2_flags_q.row_end   <= last_col;
      s2_flags_q.frame_end <= last_col && last_row;
      s2_slot_q            <= ocol_q;
      s2_pix_q             <= pix_i;
      s2_div_q             <= DIV_W'(fx_c) * DIV_W'(fy_c);
      // The entry written at this edge is not yet in the RAM's read data.
      byp_q                <= s2_valid_q && (s2_slot_q == ocol_q);
      byp_sum_q            <= new_sum;
    end
  end

  always_comb begin
    logic [SUM_W-1:0] old_v;
    logic [SUM_W-1:0] px_v;
    for (int l = 0; l < LANES; l++) begin
      old_v = byp_q ? byp_sum_q[l*SUM_W +: SUM_W] : ram_rdata[l*SUM_W +: SUM_W];
      px_v  = SUM_W'(s2_pix_q[l*PIX_W +: PIX_W]);
      new_sum[l*SUM_W +: SUM_W] = s2_first_q ? px_v : old_v + px_v;
    end
  end

  bfd_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (s2_valid_q),
    .waddr_i (s2_slot_q),
    .wdata_i (new_sum),
    .raddr_i (ocol_q),
    .rdata_o (ram_rdata)
  );

  assign job_valid_o = pending;
  assign job_sums_o  = new_sum;
  assign job_div_o   = s2_div_q;
  assign job_flags_o = s2_flags_q;

endmodule

`default_nettype wire

>>> rtl/core/bfd_queue.sv
// Short register queue of closed boxes between the front and back ends.
`default_nettype none

module bfd_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = bfd_pkg::QUEUE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [DATA_W-1:0]          data_i,
  input  wire logic                       pop_i,
  output      logic [DATA_W-1:0]          data_o,
  output      logic                       empty_o,
  output      logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0]  wptr_q, rptr_q;
  logic [CNT_W-1:0]  count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign level_o = count_q;

endmodule

`default_nettype wire

>>> rtl/core/bfd_back.sv
// Back end: four-lane restoring divider and the result register.
`default_nettype none

module bfd_back #(
  parameter int unsigned MAX_FACTOR = bfd_pkg::DEF_MAX_FACTOR
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      job_ready_i,
  input  wire logic [bfd_pkg::LANES*(bfd_pkg::PIX_W+2*$clog2(MAX_FACTOR))-1:0] job_sums_i,
  input  wire logic [bfd_pkg::DIV_W-1:0] job_div_i,
  input  wire bfd_pkg::bfd_flags_t       job_flags_i,
  output      logic                      job_pop_o,
  output      logic [bfd_pkg::PIX_W-1:0] red_out_o,
  output      logic [bfd_pkg::PIX_W-1:0] green_out_o,
  output      logic [bfd_pkg::PIX_W-1:0] blue_out_o,
  output      logic [bfd_pkg::PIX_W-1:0] alpha_out_o,
  output      logic                      row_end_o,
  output      logic                      frame_end_o,
  output      logic                      empty,
  input  wire logic                      pop
);
  import bfd_pkg::*;

  localparam int unsigned SUM_W = PIX_W + 2 * $clog2(MAX_FACTOR);
  localparam int unsigned CNT_W = $clog2(SUM_W);

  bfd_back_e        state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q [LANES];
  logic [SUM_W-1:0] quo_q [LANES];
  logic [DIV_W-1:0] rem_d [LANES];
  logic [SUM_W-1:0] quo_d [LANES];
  logic [DIV_W-1:0] div_q;
  bfd_flags_t       flags_q;
  logic             out_valid_q, load_out;
  logic [PIX_W-1:0] out_q [LANES];
  bfd_flags_t       out_flags_q;

  always_comb begin
    state_d   = state_q;
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (job_ready_i) begin
          job_pop_o = 1'b1;
          state_d   = BK_DIV;
        end
      end
      BK_DIV: begin
        if (32'(cnt_q) == SUM_W - 1) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        // The finished quotient waits here while the receiver stalls.
        if (!out_valid_q || pop) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // One quotient bit per lane per cycle, most significant first.
  always_comb begin
    logic [DIV_W:0] trial;
    for (int l = 0; l < LANES; l++) begin
      trial = {rem_q[l], quo_q[l][SUM_W-1]};
      if (trial >= {1'b0, div_q}) begin
        trial    = trial - {1'b0, div_q};
        quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b1};
      end else begin
        quo_d[l] = {quo_q[l][SUM_W-2:0], 1'b0};
      end
      rem_d[l] = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        cnt_q <= '0;
      end else if (state_q == BK_DIV) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      div_q   <= job_div_i;
      flags_q <= job_flags_i;
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= '0;
        quo_q[l] <= job_sums_i[l*SUM_W +: SUM_W];
      end
    end else if (state_q == BK_DIV) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= rem_d[l];
        quo_q[l] <= quo_d[l];
      end
    end
    if (load_out) begin
      out_flags_q <= flags_q;
      for (int l = 0; l < LANES; l++) begin
        out_q[l] <= quo_q[l][PIX_W-1:0];
      end
    end
  end

  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];
  assign alpha_out_o = out_q[3];
  assign row_end_o   = out_flags_q.row_end;
  assign frame_end_o = out_flags_q.frame_end;
  assign empty       = !out_valid_q;

endmodule

`default_nettype wire
